// ===== hdl/sip_pkg.sv =====
// sip_pkg: widths, item types and small helpers for the segment intersection block
// no dependencies; used by every other file in hdl
`default_nettype none

package sip_pkg;

   localparam int COORD_WIDTH = 32;                          // active coordinate bits
   localparam int FIELD_WIDTH = 32;                          // port field width
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;             // line coefficients a, b
   localparam int AXP_WIDTH   = DIFF_WIDTH + COORD_WIDTH;    // a*x products
   localparam int LINE_WIDTH  = AXP_WIDTH + 1;               // line constant c
   localparam int DD_WIDTH    = 2 * DIFF_WIDTH;              // a*b products
   localparam int DET_WIDTH   = DD_WIDTH + 1;                // determinant
   localparam int CLO_WIDTH   = DIFF_WIDTH;                  // low part of c, unsigned
   localparam int CHI_WIDTH   = LINE_WIDTH - CLO_WIDTH;      // high part of c, signed
   localparam int PHI_WIDTH   = DIFF_WIDTH + CHI_WIDTH;
   localparam int PLO_WIDTH   = DIFF_WIDTH + CLO_WIDTH + 1;
   localparam int NUM_WIDTH   = DIFF_WIDTH + LINE_WIDTH + 1; // cramer numerators
   localparam int QUOT_BITS   = COORD_WIDTH + 1;             // quotient bits developed
   localparam int FLOOR_WIDTH = QUOT_BITS + 2;               // signed floor quotient
   localparam int LIMIT_WIDTH = 32;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 32'd4294967;
   localparam int FRONT_STAGES = 7;
   localparam int DIV_STAGES   = QUOT_BITS + 2;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] first_start_x;
      logic signed [FIELD_WIDTH-1:0] first_start_y;
      logic signed [FIELD_WIDTH-1:0] first_end_x;
      logic signed [FIELD_WIDTH-1:0] first_end_y;
      logic signed [FIELD_WIDTH-1:0] second_start_x;
      logic signed [FIELD_WIDTH-1:0] second_start_y;
      logic signed [FIELD_WIDTH-1:0] second_end_x;
      logic signed [FIELD_WIDTH-1:0] second_end_y;
   } req_item_type;

   typedef struct packed {
      logic                          hit;
      logic signed [FIELD_WIDTH-1:0] cross_x;
      logic signed [FIELD_WIDTH-1:0] cross_y;
   } rsp_item_type;

   typedef struct packed {
      logic                          ok;
      logic                          n_neg;
      logic [NUM_WIDTH-1:0]          n_mag;
      logic [DET_WIDTH-1:0]          d;
      logic signed [COORD_WIDTH-1:0] lo;
      logic signed [COORD_WIDTH-1:0] hi;
   } div_in_type;

   typedef struct packed {
      logic                          in_box;
      logic signed [COORD_WIDTH-1:0] quot;
   } div_out_type;

   function automatic logic signed [COORD_WIDTH-1:0] smin(
      input logic signed [COORD_WIDTH-1:0] a, input logic signed [COORD_WIDTH-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] smax(
      input logic signed [COORD_WIDTH-1:0] a, input logic signed [COORD_WIDTH-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic in_rng(input logic signed [COORD_WIDTH-1:0] v,
      input logic signed [COORD_WIDTH-1:0] a, input logic signed [COORD_WIDTH-1:0] b);
      return (v >= smin(a, b)) && (v <= smax(a, b));
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sip_if.sv =====
// sip_req_if / sip_rsp_if: valid-ready channels for segment pairs and crossing results
// depends on sip_pkg for field widths
`default_nettype none

interface sip_req_if;
   import sip_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] first_start_x;
   logic signed [FIELD_WIDTH-1:0] first_start_y;
   logic signed [FIELD_WIDTH-1:0] first_end_x;
   logic signed [FIELD_WIDTH-1:0] first_end_y;
   logic signed [FIELD_WIDTH-1:0] second_start_x;
   logic signed [FIELD_WIDTH-1:0] second_start_y;
   logic signed [FIELD_WIDTH-1:0] second_end_x;
   logic signed [FIELD_WIDTH-1:0] second_end_y;

   modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                   second_start_x, second_start_y, second_end_x, second_end_y,
                   input ready);
   modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                 second_start_x, second_start_y, second_end_x, second_end_y,
                 output ready);
endinterface

interface sip_rsp_if;
   import sip_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [FIELD_WIDTH-1:0] cross_x;
   logic signed [FIELD_WIDTH-1:0] cross_y;

   modport source (output valid, hit, cross_x, cross_y, input ready);
   modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

// ===== hdl/sip_front.sv =====
// sip_front: quick test, line equations, determinant and cramer numerators (7 stages)
// depends on sip_pkg; feeds two sip_div instances
`default_nettype none

module sip_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire sip_pkg::req_item_type           in_item,
   input  wire logic [sip_pkg::LIMIT_WIDTH-1:0] limit,
   output logic                                 out_valid,
   output sip_pkg::div_in_type                  div_x,
   output sip_pkg::div_in_type                  div_y
);
   import sip_pkg::*;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] xlo;
      logic signed [COORD_WIDTH-1:0] xhi;
      logic signed [COORD_WIDTH-1:0] ylo;
      logic signed [COORD_WIDTH-1:0] yhi;
   } bounds_type;

   typedef struct packed {
      logic                          quick;
      logic signed [DIFF_WIDTH-1:0]  a1, b1, a2, b2;
      logic signed [COORD_WIDTH-1:0] x0, y0, x2, y2;
      bounds_type                    bnd;
   } s1_type;

   typedef struct packed {
      logic                         quick;
      logic signed [DIFF_WIDTH-1:0] a1, b1, a2, b2;
      logic signed [AXP_WIDTH-1:0]  p_a1x0, p_b1y0, p_a2x2, p_b2y2;
      logic signed [DD_WIDTH-1:0]   p_a1b2, p_a2b1;
      bounds_type                   bnd;
   } s2_type;

   typedef struct packed {
      logic                         quick;
      logic signed [DIFF_WIDTH-1:0] a1, b1, a2, b2;
      logic signed [LINE_WIDTH-1:0] c1, c2;
      logic signed [DET_WIDTH-1:0]  det;
      bounds_type                   bnd;
   } s3_type;

   typedef struct packed {
      logic                        ok;
      logic                        det_neg;
      logic [DET_WIDTH-1:0]        dmag;
      logic signed [PHI_WIDTH-1:0] bc1h, bc2h, ac2h, ac1h;
      logic signed [PLO_WIDTH-1:0] bc1l, bc2l, ac2l, ac1l;
      bounds_type                  bnd;
   } s4_type;

   typedef struct packed {
      logic                        ok;
      logic                        det_neg;
      logic [DET_WIDTH-1:0]        dmag;
      logic signed [NUM_WIDTH-1:0] t_bc1, t_bc2, t_ac2, t_ac1;
      bounds_type                  bnd;
   } s5_type;

   typedef struct packed {
      logic                        ok;
      logic [DET_WIDTH-1:0]        dmag;
      logic signed [NUM_WIDTH-1:0] nx, ny;
      bounds_type                  bnd;
   } s6_type;

   logic [FRONT_STAGES-1:0] v_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   div_in_type dx_ff, dx_in, dy_ff, dy_in;

   // setup: quick test, coefficients, overlap of the two bounding boxes
   always_comb begin
      logic signed [COORD_WIDTH-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
      x0 = COORD_WIDTH'(in_item.first_start_x);
      y0 = COORD_WIDTH'(in_item.first_start_y);
      x1 = COORD_WIDTH'(in_item.first_end_x);
      y1 = COORD_WIDTH'(in_item.first_end_y);
      x2 = COORD_WIDTH'(in_item.second_start_x);
      y2 = COORD_WIDTH'(in_item.second_start_y);
      x3 = COORD_WIDTH'(in_item.second_end_x);
      y3 = COORD_WIDTH'(in_item.second_end_y);
      s1_in.quick = (in_rng(x2, x0, x1) || in_rng(x3, x0, x1)) &&
                    (in_rng(y2, y0, y1) || in_rng(y3, y0, y1));
      s1_in.a1 = DIFF_WIDTH'(y1) - DIFF_WIDTH'(y0);
      s1_in.b1 = DIFF_WIDTH'(x0) - DIFF_WIDTH'(x1);
      s1_in.a2 = DIFF_WIDTH'(y3) - DIFF_WIDTH'(y2);
      s1_in.b2 = DIFF_WIDTH'(x2) - DIFF_WIDTH'(x3);
      s1_in.x0 = x0;
      s1_in.y0 = y0;
      s1_in.x2 = x2;
      s1_in.y2 = y2;
      s1_in.bnd.xlo = smax(smin(x0, x1), smin(x2, x3));
      s1_in.bnd.xhi = smin(smax(x0, x1), smax(x2, x3));
      s1_in.bnd.ylo = smax(smin(y0, y1), smin(y2, y3));
      s1_in.bnd.yhi = smin(smax(y0, y1), smax(y2, y3));
   end

   always_comb begin
      s2_in.quick  = s1_ff.quick;
      s2_in.a1     = s1_ff.a1;
      s2_in.b1     = s1_ff.b1;
      s2_in.a2     = s1_ff.a2;
      s2_in.b2     = s1_ff.b2;
      s2_in.p_a1x0 = AXP_WIDTH'(s1_ff.a1) * AXP_WIDTH'(s1_ff.x0);
      s2_in.p_b1y0 = AXP_WIDTH'(s1_ff.b1) * AXP_WIDTH'(s1_ff.y0);
      s2_in.p_a2x2 = AXP_WIDTH'(s1_ff.a2) * AXP_WIDTH'(s1_ff.x2);
      s2_in.p_b2y2 = AXP_WIDTH'(s1_ff.b2) * AXP_WIDTH'(s1_ff.y2);
      s2_in.p_a1b2 = DD_WIDTH'(s1_ff.a1) * DD_WIDTH'(s1_ff.b2);
      s2_in.p_a2b1 = DD_WIDTH'(s1_ff.a2) * DD_WIDTH'(s1_ff.b1);
      s2_in.bnd    = s1_ff.bnd;
   end

   always_comb begin
      s3_in.quick = s2_ff.quick;
      s3_in.a1    = s2_ff.a1;
      s3_in.b1    = s2_ff.b1;
      s3_in.a2    = s2_ff.a2;
      s3_in.b2    = s2_ff.b2;
      s3_in.c1    = LINE_WIDTH'(s2_ff.p_a1x0) + LINE_WIDTH'(s2_ff.p_b1y0);
      s3_in.c2    = LINE_WIDTH'(s2_ff.p_a2x2) + LINE_WIDTH'(s2_ff.p_b2y2);
      s3_in.det   = DET_WIDTH'(s2_ff.p_a1b2) - DET_WIDTH'(s2_ff.p_a2b1);
      s3_in.bnd   = s2_ff.bnd;
   end

   // numerator products with c split into a signed high and an unsigned low half
   always_comb begin
      logic signed [CHI_WIDTH-1:0] c1h, c2h;
      logic signed [PLO_WIDTH-1:0] c1l, c2l;
      logic [DET_WIDTH-1:0]        mag;
      c1h = signed'(s3_ff.c1[LINE_WIDTH-1:CLO_WIDTH]);
      c2h = signed'(s3_ff.c2[LINE_WIDTH-1:CLO_WIDTH]);
      c1l = PLO_WIDTH'(signed'({1'b0, s3_ff.c1[CLO_WIDTH-1:0]}));
      c2l = PLO_WIDTH'(signed'({1'b0, s3_ff.c2[CLO_WIDTH-1:0]}));
      mag = s3_ff.det[DET_WIDTH-1] ? DET_WIDTH'(-s3_ff.det) : DET_WIDTH'(s3_ff.det);
      s4_in.det_neg = s3_ff.det[DET_WIDTH-1];
      s4_in.dmag    = mag;
      s4_in.ok      = s3_ff.quick && (mag != '0) && !(mag < DET_WIDTH'(limit));
      s4_in.bc1h    = PHI_WIDTH'(s3_ff.b2) * PHI_WIDTH'(c1h);
      s4_in.bc2h    = PHI_WIDTH'(s3_ff.b1) * PHI_WIDTH'(c2h);
      s4_in.ac2h    = PHI_WIDTH'(s3_ff.a1) * PHI_WIDTH'(c2h);
      s4_in.ac1h    = PHI_WIDTH'(s3_ff.a2) * PHI_WIDTH'(c1h);
      s4_in.bc1l    = PLO_WIDTH'(s3_ff.b2) * c1l;
      s4_in.bc2l    = PLO_WIDTH'(s3_ff.b1) * c2l;
      s4_in.ac2l    = PLO_WIDTH'(s3_ff.a1) * c2l;
      s4_in.ac1l    = PLO_WIDTH'(s3_ff.a2) * c1l;
      s4_in.bnd     = s3_ff.bnd;
   end

   always_comb begin
      s5_in.ok      = s4_ff.ok;
      s5_in.det_neg = s4_ff.det_neg;
      s5_in.dmag    = s4_ff.dmag;
      s5_in.t_bc1   = (NUM_WIDTH'(s4_ff.bc1h) <<< CLO_WIDTH) + NUM_WIDTH'(s4_ff.bc1l);
      s5_in.t_bc2   = (NUM_WIDTH'(s4_ff.bc2h) <<< CLO_WIDTH) + NUM_WIDTH'(s4_ff.bc2l);
      s5_in.t_ac2   = (NUM_WIDTH'(s4_ff.ac2h) <<< CLO_WIDTH) + NUM_WIDTH'(s4_ff.ac2l);
      s5_in.t_ac1   = (NUM_WIDTH'(s4_ff.ac1h) <<< CLO_WIDTH) + NUM_WIDTH'(s4_ff.ac1l);
      s5_in.bnd     = s4_ff.bnd;
   end

   // sign of the determinant folded into the numerators so the divisor is positive
   always_comb begin
      s6_in.ok   = s5_ff.ok;
      s6_in.dmag = s5_ff.dmag;
      s6_in.nx   = s5_ff.det_neg ? (s5_ff.t_bc2 - s5_ff.t_bc1) : (s5_ff.t_bc1 - s5_ff.t_bc2);
      s6_in.ny   = s5_ff.det_neg ? (s5_ff.t_ac1 - s5_ff.t_ac2) : (s5_ff.t_ac2 - s5_ff.t_ac1);
      s6_in.bnd  = s5_ff.bnd;
   end

   always_comb begin
      dx_in.ok    = s6_ff.ok;
      dx_in.n_neg = s6_ff.nx[NUM_WIDTH-1];
      dx_in.n_mag = s6_ff.nx[NUM_WIDTH-1] ? NUM_WIDTH'(-s6_ff.nx) : NUM_WIDTH'(s6_ff.nx);
      dx_in.d     = s6_ff.dmag;
      dx_in.lo    = s6_ff.bnd.xlo;
      dx_in.hi    = s6_ff.bnd.xhi;
      dy_in.ok    = s6_ff.ok;
      dy_in.n_neg = s6_ff.ny[NUM_WIDTH-1];
      dy_in.n_mag = s6_ff.ny[NUM_WIDTH-1] ? NUM_WIDTH'(-s6_ff.ny) : NUM_WIDTH'(s6_ff.ny);
      dy_in.d     = s6_ff.dmag;
      dy_in.lo    = s6_ff.bnd.ylo;
      dy_in.hi    = s6_ff.bnd.yhi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   assign out_valid = v_ff[FRONT_STAGES-1];
   assign div_x     = dx_ff;
   assign div_y     = dy_ff;

endmodule

`default_nettype wire

// ===== hdl/sip_div.sv =====
// sip_div: pipelined restoring divider, one quotient bit per stage, with exact box test
// depends on sip_pkg; two instances sit in segment_intersection_point_top
`default_nettype none

module sip_div (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire sip_pkg::div_in_type d_in,
   output sip_pkg::div_out_type     res
);
   import sip_pkg::*;

   typedef struct packed {
      logic                          ok;
      logic                          n_neg;
      logic [DET_WIDTH-1:0]          rem;
      logic [QUOT_BITS-1:0]          low;
      logic [QUOT_BITS-1:0]          q;
      logic [DET_WIDTH-1:0]          d;
      logic signed [COORD_WIDTH-1:0] lo;
      logic signed [COORD_WIDTH-1:0] hi;
   } stage_type;

   stage_type   stg_ff [0:QUOT_BITS];
   stage_type   stg_in [0:QUOT_BITS];
   div_out_type res_ff, res_in;

   // a quotient too large for the developed bits lies outside every box anyway
   always_comb begin
      stg_in[0].ok    = d_in.ok && (d_in.n_mag[NUM_WIDTH-1:QUOT_BITS] < d_in.d);
      stg_in[0].n_neg = d_in.n_neg;
      stg_in[0].rem   = d_in.n_mag[NUM_WIDTH-1:QUOT_BITS];
      stg_in[0].low   = d_in.n_mag[QUOT_BITS-1:0];
      stg_in[0].q     = '0;
      stg_in[0].d     = d_in.d;
      stg_in[0].lo    = d_in.lo;
      stg_in[0].hi    = d_in.hi;
   end

   for (genvar g = 0; g < QUOT_BITS; g++) begin : g_step
      always_comb begin
         logic [DET_WIDTH:0] trial;
         logic               ge;
         trial = {stg_ff[g].rem, stg_ff[g].low[QUOT_BITS-1-g]};
         ge    = trial >= {1'b0, stg_ff[g].d};
         stg_in[g+1]     = stg_ff[g];
         stg_in[g+1].rem = ge ? DET_WIDTH'(trial - {1'b0, stg_ff[g].d}) : DET_WIDTH'(trial);
         stg_in[g+1].q[QUOT_BITS-1-g] = ge;
      end
   end

   for (genvar g = 0; g <= QUOT_BITS; g++) begin : g_reg
      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[g] <= stg_in[g];
         end
      end
   end

   // floor of the signed quotient, then inclusive test on the exact value
   always_comb begin
      logic                          inexact;
      logic signed [FLOOR_WIDTH-1:0] qs, fq, lo_e, hi_e, ix;
      inexact = (stg_ff[QUOT_BITS].rem != '0);
      qs      = signed'(FLOOR_WIDTH'(stg_ff[QUOT_BITS].q));
      ix      = signed'(FLOOR_WIDTH'(inexact));
      fq      = stg_ff[QUOT_BITS].n_neg ? (-qs - ix) : qs;
      lo_e    = FLOOR_WIDTH'(stg_ff[QUOT_BITS].lo);
      hi_e    = FLOOR_WIDTH'(stg_ff[QUOT_BITS].hi);
      res_in.in_box = stg_ff[QUOT_BITS].ok && (fq >= lo_e) &&
                      ((fq < hi_e) || ((fq == hi_e) && !inexact));
      res_in.quot   = signed'(fq[COORD_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== hdl/segment_intersection_point_top.sv =====
// segment_intersection_point_top: segment pair crossing point by cramer's rule
// depends on sip_pkg, sip_if, sip_front and sip_div
//
//   channel | dir | signals                                 | transfer
//   req_if  | in  | valid/ready, eight Q16.16 coordinates   | valid && ready
//   rsp_if  | out | valid/ready, hit, cross_x, cross_y      | valid && ready
//   csr     | in  | csr_wr_en, csr_wr_data (parallel_limit) | csr_wr_en
//
// one pair per cycle while the output is not stalled; 7 front stages + 35 divider stages + 1 output register
// the divider develops one quotient bit per stage, which sets the depth
// reset (synchronous) clears all valid bits and loads parallel_limit with 0.001
// a stalled output parks one result in a skid register; the pipeline then freezes
// and req_if.ready stays low until the skid register drains
`default_nettype none

module segment_intersection_point_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sip_req_if.sink                              req_if,
   sip_rsp_if.source                            rsp_if,
   input  wire logic                            csr_wr_en,
   input  wire logic [sip_pkg::LIMIT_WIDTH-1:0] csr_wr_data
);
   import sip_pkg::*;

   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic                   en;
   logic                   front_valid;
   div_in_type             div_x, div_y;
   div_out_type            res_x, res_y;
   logic [DIV_STAGES-1:0]  dv_ff;
   logic                   take;
   req_item_type           item;
   rsp_item_type           res_item;
   rsp_item_type           out_d_ff, out_d_in, skid_d_ff, skid_d_in;
   logic                   out_v_ff, out_v_in, skid_v_ff, skid_v_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign en           = !skid_v_ff;
   assign req_if.ready = en;

   always_comb begin
      item.first_start_x  = req_if.first_start_x;
      item.first_start_y  = req_if.first_start_y;
      item.first_end_x    = req_if.first_end_x;
      item.first_end_y    = req_if.first_end_y;
      item.second_start_x = req_if.second_start_x;
      item.second_start_y = req_if.second_start_y;
      item.second_end_x   = req_if.second_end_x;
      item.second_end_y   = req_if.second_end_y;
   end

   sip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .in_item   (item),
      .limit     (limit_ff),
      .out_valid (front_valid),
      .div_x     (div_x),
      .div_y     (div_y)
   );

   sip_div u_div_x (.clock(clock), .en(en), .d_in(div_x), .res(res_x));
   sip_div u_div_y (.clock(clock), .en(en), .d_in(div_y), .res(res_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (en) begin
         dv_ff <= {dv_ff[DIV_STAGES-2:0], front_valid};
      end
   end

   always_comb begin
      res_item.hit     = res_x.in_box && res_y.in_box;
      res_item.cross_x = res_item.hit ? FIELD_WIDTH'(res_x.quot) : '0;
      res_item.cross_y = res_item.hit ? FIELD_WIDTH'(res_y.quot) : '0;
   end

   assign take = dv_ff[DIV_STAGES-1] && en;

   // output register with one skid entry behind it
   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (out_v_ff && rsp_if.ready) begin
         if (skid_v_ff) begin
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end else if (take) begin
            out_d_in = res_item;
         end else begin
            out_v_in = 1'b0;
         end
      end else if (!out_v_ff) begin
         if (take) begin
            out_v_in = 1'b1;
            out_d_in = res_item;
         end
      end else if (take) begin
         skid_v_in = 1'b1;
         skid_d_in = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_if.valid   = out_v_ff;
   assign rsp_if.hit     = out_d_ff.hit;
   assign rsp_if.cross_x = out_d_ff.cross_x;
   assign rsp_if.cross_y = out_d_ff.cross_y;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without a result in the output register");

   a_stall_parks: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_if.ready && take) |=> skid_v_ff)
      else $error("result leaving the pipeline under a stall was not parked");

   a_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(dv_ff))
      else $error("pipeline moved while the skid entry was full");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_d_ff.hit) |-> (out_d_ff.cross_x == '0 && out_d_ff.cross_y == '0))
      else $error("miss reported with nonzero coordinates");
`endif

endmodule

`default_nettype wire

// ===== tb/segment_intersection_point_top_test.sv =====
// testbench for segment_intersection_point_top: segment pairs in, crossing points out
// depends on sip_pkg, sip_if and the block itself; a scoreboard class predicts results
`timescale 1ns / 100ps

module segment_intersection_point_top_test;
   import sip_pkg::*;

   typedef logic signed [127:0] wide_type;

   localparam int CLOCK_PERIOD = 12;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 150;

   class crossing_board;
      logic [LIMIT_WIDTH-1:0] parallel_limit;
      rsp_item_type           pending[$];
      int                     mismatches;

      function new();
         parallel_limit = LIMIT_RESET;
         mismatches     = 0;
      endfunction

      function bit in_window(wide_type v, wide_type a, wide_type b);
         return (v >= ((a < b) ? a : b)) && (v <= ((a > b) ? a : b));
      endfunction

      // exact quotient lies in the closed box edge range
      function bit quot_within(wide_type q, bit inexact, wide_type a, wide_type b);
         wide_type lo;
         wide_type hi;
         lo = (a < b) ? a : b;
         hi = (a > b) ? a : b;
         return (q >= lo) && ((q < hi) || (q == hi && !inexact));
      endfunction

      function logic signed [31:0] saturate(wide_type q);
         if (q > wide_type'(32'sh7fffffff)) return 32'sh7fffffff;
         if (q < -wide_type'(64'sh80000000)) return 32'sh80000000;
         return q[31:0];
      endfunction

      function rsp_item_type predict_crossing(req_item_type it);
         wide_type x0, y0, x1, y1, x2, y2, x3, y3;
         wide_type a1, b1, c1, a2, b2, c2, det, mag, nx, ny, qx, qy, rx, ry;
         bit ix, iy;
         rsp_item_type r;
         r = '0;
         x0 = wide_type'(it.first_start_x);  y0 = wide_type'(it.first_start_y);
         x1 = wide_type'(it.first_end_x);    y1 = wide_type'(it.first_end_y);
         x2 = wide_type'(it.second_start_x); y2 = wide_type'(it.second_start_y);
         x3 = wide_type'(it.second_end_x);   y3 = wide_type'(it.second_end_y);
         if (!(in_window(x2, x0, x1) || in_window(x3, x0, x1))) return r;
         if (!(in_window(y2, y0, y1) || in_window(y3, y0, y1))) return r;
         a1 = y1 - y0; b1 = x0 - x1; c1 = a1 * x0 + b1 * y0;
         a2 = y3 - y2; b2 = x2 - x3; c2 = a2 * x2 + b2 * y2;
         det = a1 * b2 - a2 * b1;
         mag = (det < 0) ? -det : det;
         if (det == 0 || mag < wide_type'({96'b0, parallel_limit})) return r;
         nx = b2 * c1 - b1 * c2;
         ny = a1 * c2 - a2 * c1;
         qx = nx / det; rx = nx % det; ix = (rx != 0);
         qy = ny / det; ry = ny % det; iy = (ry != 0);
         // truncation to floor
         if (ix && ((nx < 0) != (det < 0))) qx = qx - 1;
         if (iy && ((ny < 0) != (det < 0))) qy = qy - 1;
         if (!quot_within(qx, ix, x0, x1) || !quot_within(qy, iy, y0, y1) ||
             !quot_within(qx, ix, x2, x3) || !quot_within(qy, iy, y2, y3)) return r;
         r.hit     = 1'b1;
         r.cross_x = saturate(qx);
         r.cross_y = saturate(qy);
         return r;
      endfunction

      function void note_pair(req_item_type it);
         pending.push_back(predict_crossing(it));
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
         mismatches++;
      endtask

      task check_crossing(rsp_item_type got);
         rsp_item_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transfer", {31'b0, got.hit}, 32'b0);
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit) report_mismatch("hit", {31'b0, got.hit}, {31'b0, want.hit});
         if (got.cross_x !== want.cross_x) report_mismatch("cross_x", got.cross_x, want.cross_x);
         if (got.cross_y !== want.cross_y) report_mismatch("cross_y", got.cross_y, want.cross_y);
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LIMIT_WIDTH-1:0] csr_wr_data;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   crossing_board board;

   sip_req_if req_if();
   sip_rsp_if rsp_if();

   segment_intersection_point_top DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function req_item_type make_pair(logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy);
      req_item_type it;
      it.first_start_x = ax;  it.first_start_y = ay;
      it.first_end_x = bx;    it.first_end_y = by;
      it.second_start_x = cx; it.second_start_y = cy;
      it.second_end_x = dx;   it.second_end_y = dy;
      return it;
   endfunction

   function logic signed [31:0] rnd(int shift);
      return $signed($urandom()) >>> shift;
   endfunction

   // mostly pairs that cross, some parallel, shared endpoints and raw noise
   function req_item_type random_pair();
      int kind;
      int s;
      logic signed [31:0] cx, cy, dx, dy, ex, ey, ox, oy;
      kind = $urandom_range(0, 99);
      s  = $urandom_range(1, 24);
      cx = rnd(s); cy = rnd(s);
      dx = rnd(s + 1); dy = rnd(s + 1);
      ex = rnd(s + 1); ey = rnd(s + 1);
      ox = rnd(s + 2); oy = rnd(s + 2);
      if (kind < 60)
         return make_pair(cx - dx, cy - dy, cx + (dx >>> $urandom_range(0, 2)),
                          cy + (dy >>> $urandom_range(0, 2)),
                          cx - ex, cy - ey, cx + ex, cy + ey);
      if (kind < 72)
         return make_pair(cx, cy, cx + dx, cy + dy, cx + ox, cy + oy,
                          cx + dx + ox, cy + dy + oy);
      if (kind < 82)
         return make_pair(cx, cy, cx + dx, cy + dy, cx + dx, cy + dy,
                          cx + dx + ex, cy + dy + ey);
      return make_pair($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom());
   endfunction

   task send_pair(req_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.first_start_x <= it.first_start_x;
      req_if.first_start_y <= it.first_start_y;
      req_if.first_end_x <= it.first_end_x;
      req_if.first_end_y <= it.first_end_y;
      req_if.second_start_x <= it.second_start_x;
      req_if.second_start_y <= it.second_start_y;
      req_if.second_end_x <= it.second_end_x;
      req_if.second_end_y <= it.second_end_y;
      do @(posedge clock); while (!req_if.ready);
      board.note_pair(it);
   endtask

   task settle();
      req_if.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_limit(logic [LIMIT_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.parallel_limit = value;
   endtask

   task run_phase(logic [LIMIT_WIDTH-1:0] limit, int idle, int stall);
      settle();
      write_limit(limit);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (PHASE_ITEMS) send_pair(random_pair());
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_crossing('{hit: rsp_if.hit, cross_x: rsp_if.cross_x,
                                cross_y: rsp_if.cross_y});
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      board          = new();
      quiet_cycles   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.first_start_x = '0;  req_if.first_start_y = '0;
      req_if.first_end_x = '0;    req_if.first_end_y = '0;
      req_if.second_start_x = '0; req_if.second_start_y = '0;
      req_if.second_end_x = '0;   req_if.second_end_y = '0;
      rsp_if.ready   = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pairs at the reset limit
      send_pair(make_pair(0, 0, 32'sh20000, 32'sh20000, 0, 32'sh20000, 32'sh20000, 0));
      send_pair(make_pair(0, 0, 32'sh30000, 32'sh10000, 32'sh10000, 32'sh20000,
                          32'sh20000, 32'sh10000));
      // quick test fails on x, then on y
      send_pair(make_pair(0, 0, 32'sh10000, 32'sh10000, 32'sh50000, 0, 32'sh60000, 0));
      send_pair(make_pair(0, 0, 32'sh10000, 32'sh10000, 0, 32'sh50000, 32'sh10000, 32'sh60000));
      // crossing on an endpoint, inclusive box
      send_pair(make_pair(0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
                          32'sh20000, 0));
      // lines cross outside the second box
      send_pair(make_pair(0, 0, 32'sh40000, 32'sh40000, 32'sh10000, 0, 32'sh20000, 32'sh10));
      // parallel, collinear, zero-length segments
      send_pair(make_pair(0, 0, 32'sh10000, 32'sh10000, 0, 32'sh100, 32'sh10000, 32'sh10100));
      send_pair(make_pair(0, 0, 32'sh20000, 32'sh20000, 32'sh10000, 32'sh10000,
                          32'sh30000, 32'sh30000));
      send_pair(make_pair(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
                          32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000));
      // near-parallel: tiny determinant below the reset limit
      send_pair(make_pair(0, 0, 32'sh10000, 32'sh10000, 0, 1, 32'sh10000, 32'sh10000));
      // inexact quotient, rounding toward minus infinity
      send_pair(make_pair(-32'sh10000, -32'sh3, 32'sh10000, 32'sh7, -32'sh3, 32'sh10000,
                          32'sh1, -32'sh10000));
      // field extremes
      send_pair(make_pair(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
      send_pair(make_pair(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
      send_pair(make_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      send_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
      send_pair(make_pair(32'sh80000000, 0, 32'sh7fffffff, 0, 0, 32'sh80000000,
                          0, 32'sh7fffffff));
      repeat (PHASE_ITEMS - 16) send_pair(random_pair());

      run_phase('0, 48, 0);
      run_phase(32'hffffffff, 0, 48);
      run_phase(32'd1, 22, 22);
      run_phase($urandom(), 0, 0);
      run_phase(LIMIT_RESET, 22, 22);

      settle();
      if (board.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
